// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the autorepeat value editor core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion, ignored while reset is asserted.
`define AVR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// Clocked assertion, checked also during reset.
`define AVR_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("assertion failed");
`else
`define AVR_ASSERT(lbl, clk, rst_n, prop)
`define AVR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/core/avr_pkg.sv =====
// Shared types and constants of the autorepeat value editor.
package avr_pkg;

	localparam int FIRST_HIT     = 2;
	localparam int REPEAT_DELAY  = 50;
	localparam int REPEAT_PERIOD = 5;
	localparam int FAST_DELAY    = 200;
	localparam int FASTER_DELAY  = 400;

	localparam logic [15:0] HOLD_GUARD = 16'hFFFA;

	localparam int RES_W = $clog2(REPEAT_PERIOD + 1);
	localparam logic [RES_W-1:0] RES_ONE  = RES_W'(1 % REPEAT_PERIOD);
	localparam logic [RES_W-1:0] RES_LAST = RES_W'(REPEAT_PERIOD - 1);

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN   = 3'd0,
		REG_MAX   = 3'd1,
		REG_STEP  = 3'd2,
		REG_ACCEL = 3'd3,
		REG_WRAP  = 3'd4,
		REG_INIT  = 3'd5
	} avr_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_UP,
		ST_DOWN
	} avr_state_t;

	typedef struct packed {
		logic up_pressed;
		logic down_pressed;
	} avr_in_t;

	typedef struct packed {
		logic [15:0] value;
		logic        changed;
	} avr_out_t;

	typedef struct packed {
		logic accept;
		logic mul1;
		logic mul2;
		logic apply_up;
		logic commit;
	} avr_cmd_t;

endpackage

// ===== rtl/core/autorepeat_value_editor_core.sv =====
// Top level of the autorepeat value editor: controller plus datapath.
//
//  channel   direction  handshake            payload
//  in        to core    in_valid / in_stall    in_data   (up_pressed, down_pressed)
//  out       from core  out_valid / out_stall  out_data  (value, changed)
//  cfg       to core    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request runs in order through accept with counter update, two multiply steps
// for the accelerated step, the up update, and the down update with result write.
// The shared step multiplier path and the single value register set this order.
// A waiting result holds in the output register; a new request is taken meanwhile,
// and its result write waits only while the output register is full and stalled.
// Reset loads the register defaults and clears the hold counters; no clearing pass.
module autorepeat_value_editor_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  avr_pkg::avr_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output avr_pkg::avr_out_t             out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [avr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);
	import avr_pkg::*;

	avr_cmd_t cmd;

	assign cfg_ready = 1'b1;

	avr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	avr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/core/avr_ctrl.sv =====
// Controller state machine: sequences one request and owns the output valid.
`include "assert_macros.svh"
module avr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output avr_pkg::avr_cmd_t cmd
);
	import avr_pkg::*;

	avr_state_t state_q;
	avr_state_t state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_MUL1;
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_UP;
			ST_UP:   state_d = ST_DOWN;
			ST_DOWN: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		in_stall     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_MUL1: cmd.mul1 = 1'b1;
			ST_MUL2: cmd.mul2 = 1'b1;
			ST_UP:   cmd.apply_up = 1'b1;
			ST_DOWN: cmd.commit = slot_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`AVR_ASSERT(a_commit_sets_valid, clk, arst_n, cmd.commit |=> out_valid_q)
	`AVR_ASSERT(a_no_overwrite, clk, arst_n, !(cmd.commit && out_valid_q && out_stall))
	`AVR_ASSERT(a_accept_to_mul, clk, arst_n, cmd.accept |=> (state_q == ST_MUL1))
	`AVR_ASSERT(a_down_waits, clk, arst_n, (state_q == ST_DOWN && !cmd.commit) |=> state_q == ST_DOWN)

endmodule

// ===== rtl/core/avr_dp.sv =====
// Datapath: hold counters, step multiply, value update and result register.
module avr_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  avr_pkg::avr_cmd_t             cmd,
	input  avr_pkg::avr_in_t              in_data,
	input  logic                          cfg_we,
	input  logic [avr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data,
	output avr_pkg::avr_out_t             out_data
);
	import avr_pkg::*;

	logic [15:0]      min_q;
	logic [15:0]      max_q;
	logic [7:0]       step_size_q;
	logic [3:0]       accel_q;
	logic             wrap_q;

	logic [15:0]      up_cnt_q;
	logic [15:0]      dn_cnt_q;
	logic [RES_W-1:0] up_res_q;
	logic [RES_W-1:0] dn_res_q;
	logic             fire_up_q;
	logic             fire_dn_q;
	logic [11:0]      step_s1;
	logic [15:0]      step_s2;
	logic [15:0]      value_q;
	avr_out_t         out_q;

	logic [15:0]      up_cnt_d;
	logic [15:0]      dn_cnt_d;
	logic [RES_W-1:0] up_res_d;
	logic [RES_W-1:0] dn_res_d;
	logic             fast;
	logic             faster;
	logic [3:0]       mul_a;
	logic [3:0]       mul_b;
	logic [16:0]      sum_up;
	logic [15:0]      v_up;
	logic [16:0]      lim_dn;
	logic [15:0]      v_dn;

	function automatic logic [15:0] next_count(input logic [15:0] cnt, input logic lvl);
		logic [15:0] g;
		g = (cnt > HOLD_GUARD) ? 16'd1 : cnt;
		return lvl ? (g + 16'd1) : 16'd0;
	endfunction

	function automatic logic [RES_W-1:0] next_res(input logic [15:0] cnt,
			input logic [RES_W-1:0] res, input logic lvl);
		logic [RES_W-1:0] g;
		g = (cnt > HOLD_GUARD) ? RES_ONE : res;
		if (!lvl) return '0;
		return (g == RES_LAST) ? '0 : (g + RES_W'(1));
	endfunction

	function automatic logic fires(input logic [15:0] cnt, input logic [RES_W-1:0] res);
		return (cnt == 16'(FIRST_HIT)) || ((cnt > 16'(REPEAT_DELAY)) && (res == '0));
	endfunction

	assign up_cnt_d = next_count(up_cnt_q, in_data.up_pressed);
	assign dn_cnt_d = next_count(dn_cnt_q, in_data.down_pressed);
	assign up_res_d = next_res(up_cnt_q, up_res_q, in_data.up_pressed);
	assign dn_res_d = next_res(dn_cnt_q, dn_res_q, in_data.down_pressed);

	assign fast   = (up_cnt_q > 16'(FAST_DELAY)) || (dn_cnt_q > 16'(FAST_DELAY));
	assign faster = (up_cnt_q > 16'(FASTER_DELAY)) || (dn_cnt_q > 16'(FASTER_DELAY));
	assign mul_a  = fast ? accel_q : 4'd1;
	assign mul_b  = faster ? accel_q : 4'd1;

	always_comb begin
		sum_up = {1'b0, value_q} + {1'b0, step_s2};
		if (sum_up > {1'b0, max_q}) begin
			v_up = wrap_q ? 16'(sum_up - {1'b0, max_q} - 17'd1) : max_q;
		end else begin
			v_up = sum_up[15:0];
		end
	end

	always_comb begin
		lim_dn = {1'b0, min_q} + {1'b0, step_s2};
		if (wrap_q) begin
			if (value_q > step_s2) v_dn = value_q - step_s2;
			else v_dn = max_q + value_q + 16'd1 - step_s2;
		end else begin
			if ({1'b0, value_q} > lim_dn) v_dn = value_q - step_s2;
			else v_dn = min_q;
		end
		if (!fire_dn_q) v_dn = value_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= 16'd0;
			max_q       <= 16'hFFFF;
			step_size_q <= 8'd1;
			accel_q     <= 4'd1;
			wrap_q      <= 1'b0;
			value_q     <= 16'd0;
			up_cnt_q    <= 16'd0;
			dn_cnt_q    <= 16'd0;
			up_res_q    <= '0;
			dn_res_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN:   min_q <= cfg_data;
					REG_MAX:   max_q <= cfg_data;
					REG_STEP:  step_size_q <= cfg_data[7:0];
					REG_ACCEL: accel_q <= cfg_data[3:0];
					REG_WRAP:  wrap_q <= cfg_data[0];
					REG_INIT:  value_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				up_cnt_q <= up_cnt_d;
				dn_cnt_q <= dn_cnt_d;
				up_res_q <= up_res_d;
				dn_res_q <= dn_res_d;
			end
			if (cmd.apply_up && fire_up_q) begin
				value_q <= v_up;
			end
			if (cmd.commit) begin
				value_q <= v_dn;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			step_s1   <= step_size_q * mul_a;
			fire_up_q <= fires(up_cnt_q, up_res_q);
			fire_dn_q <= fires(dn_cnt_q, dn_res_q);
		end
		if (cmd.mul2) begin
			step_s2 <= step_s1 * mul_b;
		end
		if (cmd.commit) begin
			out_q.value   <= v_dn;
			out_q.changed <= fire_up_q | fire_dn_q;
		end
	end

	assign out_data = out_q;

endmodule
